### sv/mse_pkg.sv
// Shared types for the merge sort engine.
// No dependencies; every other file of the block but mse_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

	// Sequencer phases: fill buffer A, set up a pass, merge runs, stream out.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PREP,
		ST_MERGE,
		ST_EMIT
	} mse_state_t;

	localparam int unsigned FIELD_WIDTH = 32;

endpackage

`default_nettype wire

### sv/mse_if.sv
// Valid/ready channels of the merge sort engine: load beats in, sorted beats out.
// Depends on mse_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface mse_in_if;
	import mse_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [FIELD_WIDTH-1:0] value;
	logic                          last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface mse_out_if;
	import mse_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [FIELD_WIDTH-1:0] sorted_value;
	logic                          last_out;

	modport source (output valid, output sorted_value, output last_out, input ready);
	modport sink (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

### sv/merge_sort_engine_unit.sv
// Top level of the merge sort engine: sequencer plus two run buffers.
// Depends on mse_pkg, mse_if, mse_ram and mse_seq.
`timescale 1ns / 1ps
`default_nettype none

// Load up to MAX_ITEMS signed values, one per beat on load; the beat with last
// set (or the beat that fills the buffer) closes the set. The set is then
// sorted ascending by a stable bottom-up merge sort that ping-pongs between
// two buffer memories, and every value comes out on result in order, the
// final beat with last_out set. Values are kept as DATA_WIDTH-bit signed
// numbers. For a set of n values the block loads the values, then runs
// ceil(log2 n) merge passes, each a setup step followed by a merge of the
// whole set, then takes one more setup step and streams the values out. The
// merge pass writes one value a cycle, set by the single write port of each
// buffer. Loading of the next set starts while the final sorted beat still
// waits in the output register.

module merge_sort_engine_unit #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mse_in_if.sink    load,
	mse_out_if.source result
);

	import mse_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);

	logic                  a_we, b_we;
	logic [AW-1:0]         waddr, raddr_i, raddr_j;
	logic [DATA_WIDTH-1:0] wdata, a_rd_i, a_rd_j, b_rd_i, b_rd_j;

	mse_seq #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DATA_WIDTH),
		.AW        (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.result (result),
		.a_we   (a_we),
		.b_we   (b_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_i(raddr_i),
		.raddr_j(raddr_j),
		.a_rd_i (a_rd_i),
		.a_rd_j (a_rd_j),
		.b_rd_i (b_rd_i),
		.b_rd_j (b_rd_j)
	);

	mse_ram #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(DATA_WIDTH),
		.AW   (AW)
	) u_buf_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr_i),
		.raddr1(raddr_j),
		.rdata0(a_rd_i),
		.rdata1(a_rd_j)
	);

	mse_ram #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(DATA_WIDTH),
		.AW   (AW)
	) u_buf_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr_i),
		.raddr1(raddr_j),
		.rdata0(b_rd_i),
		.rdata1(b_rd_j)
	);

	// A merge writes only its destination buffer.
	a_one_dst: assert property (@(posedge clk) disable iff (!arst_n)
		!(a_we && b_we))
		else $error("both run buffers written in one cycle");

	// No load beat while a pass into buffer B is running.
	a_no_load_in_merge: assert property (@(posedge clk) disable iff (!arst_n)
		b_we |-> !load.ready)
		else $error("load accepted during a merge pass");

	// Hold a stalled result beat unchanged until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=>
		(result.valid && $stable(result.sorted_value) && $stable(result.last_out)))
		else $error("stalled result beat changed");

endmodule

`default_nettype wire

### sv/mse_ram.sv
// Run buffer: one write port and two registered read ports.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mse_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata0,
	output logic      [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

### sv/mse_seq.sv
// Sequencer of the merge sort engine: load, bottom-up merge passes, emit stage.
// Depends on mse_pkg and mse_if; drives the two run buffers in the top level.
`timescale 1ns / 1ps
`default_nettype none

module mse_seq #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = $clog2(MAX_ITEMS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mse_in_if.sink                     load,
	mse_out_if.source                  result,
	output logic                       a_we,
	output logic                       b_we,
	output logic [AW-1:0]              waddr,
	output logic [DATA_WIDTH-1:0]      wdata,
	output logic [AW-1:0]              raddr_i,
	output logic [AW-1:0]              raddr_j,
	input  wire logic [DATA_WIDTH-1:0] a_rd_i,
	input  wire logic [DATA_WIDTH-1:0] a_rd_j,
	input  wire logic [DATA_WIDTH-1:0] b_rd_i,
	input  wire logic [DATA_WIDTH-1:0] b_rd_j
);

	import mse_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = CW + 1;
	localparam int XW = (DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

	function automatic logic [CW-1:0] clamp_n(input logic [SW-1:0] sum,
		input logic [CW-1:0] n);
		if (sum < {1'b0, n}) begin
			clamp_n = sum[CW-1:0];
		end else begin
			clamp_n = n;
		end
	endfunction

	mse_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] width_q, width_d;
	logic          in_a_q, in_a_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
	logic [CW-1:0] mid_run;

	logic                          ovalid_q;
	logic signed [FIELD_WIDTH-1:0] odata_q;
	logic                          olast_q;

	logic [DATA_WIDTH-1:0] ri, rj, merge_d, load_data;
	logic signed [XW-1:0]  in_ext, out_ext;
	logic [CW-1:0]         cnt_inc, i_inc, j_inc, k_inc;
	logic                  load_fire, load_end, take_j, run_end, pass_end;
	logic                  sorted, emit_fire, emit_end;

	// Heads of the source runs; the final result sits in the source buffer too.
	assign ri = in_a_q ? a_rd_i : b_rd_i;
	assign rj = in_a_q ? a_rd_j : b_rd_j;

	assign in_ext    = XW'(load.value);
	assign load_data = in_ext[DATA_WIDTH-1:0];
	assign out_ext   = XW'($signed(ri));

	assign cnt_inc = cnt_q + CW'(1);
	assign i_inc   = i_q + CW'(1);
	assign j_inc   = j_q + CW'(1);
	assign k_inc   = k_q + CW'(1);

	assign load.ready = (state_q == ST_LOAD);
	assign load_fire  = load.valid && load.ready;
	// A full buffer ends the set even without the last flag.
	assign load_end   = load_fire && (load.last || cnt_inc == CNT_MAX);

	// Left head wins ties, which keeps the sort stable.
	assign take_j  = (j_q < hi_q) && ((i_q >= mid_q) || ($signed(rj) < $signed(ri)));
	assign merge_d = take_j ? rj : ri;
	assign run_end  = (k_inc == hi_q);
	assign pass_end = run_end && (hi_q == cnt_q);
	assign sorted   = (width_q >= {1'b0, cnt_q});
	assign mid_run  = clamp_n({1'b0, hi_q} + width_q, cnt_q);

	assign emit_fire = (state_q == ST_EMIT) && (!ovalid_q || result.ready);
	assign emit_end  = emit_fire && (i_inc == cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_end) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = sorted ? ST_EMIT : ST_MERGE;
			end
			ST_MERGE: begin
				if (pass_end) begin
					state_d = ST_PREP;
				end
			end
			ST_EMIT: begin
				if (emit_end) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Index updates; read addresses follow the next indices so that the
	// registered read data matches the indices of the coming cycle.
	always_comb begin
		cnt_d   = cnt_q;
		width_d = width_q;
		in_a_d  = in_a_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		mid_d   = mid_q;
		hi_d    = hi_q;
		case (state_q)
			ST_LOAD: begin
				if (load_fire) begin
					cnt_d = cnt_inc;
				end
				if (load_end) begin
					width_d = SW'(1);
					in_a_d  = 1'b1;
				end
			end
			ST_PREP: begin
				i_d   = '0;
				k_d   = '0;
				mid_d = clamp_n(width_q, cnt_q);
				j_d   = mid_d;
				hi_d  = clamp_n({1'b0, mid_d} + width_q, cnt_q);
			end
			ST_MERGE: begin
				k_d = k_inc;
				if (take_j) begin
					j_d = j_inc;
				end else begin
					i_d = i_inc;
				end
				if (pass_end) begin
					width_d = width_q << 1;
					in_a_d  = !in_a_q;
				end else if (run_end) begin
					i_d   = hi_q;
					mid_d = mid_run;
					j_d   = mid_run;
					hi_d  = clamp_n({1'b0, mid_run} + width_q, cnt_q);
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					i_d = i_inc;
				end
				if (emit_end) begin
					cnt_d = '0;
				end
			end
			default: begin
				cnt_d = '0;
			end
		endcase
	end

	always_comb begin
		a_we    = load_fire || ((state_q == ST_MERGE) && !in_a_q);
		b_we    = (state_q == ST_MERGE) && in_a_q;
		waddr   = (state_q == ST_LOAD) ? cnt_q[AW-1:0] : k_q[AW-1:0];
		wdata   = (state_q == ST_LOAD) ? load_data : merge_d;
		raddr_i = i_d[AW-1:0];
		raddr_j = j_d[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			width_q  <= '0;
			in_a_q   <= 1'b1;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			width_q <= width_d;
			in_a_q  <= in_a_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			if (emit_fire) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			odata_q <= out_ext[FIELD_WIDTH-1:0];
			olast_q <= (i_inc == cnt_q);
		end
	end

	assign result.valid        = ovalid_q;
	assign result.sorted_value = odata_q;
	assign result.last_out     = olast_q;

endmodule

`default_nettype wire

### tb/mse_sort_checker.sv
// Checker for the merge sort engine: watches the load and result channels,
// keeps its own sorted copy of every set and compares each result beat.
// Depends on mse_pkg and mse_if.
`timescale 1ns / 1ps

module mse_sort_checker #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mse_in_if           load,
	mse_out_if          result,
	output int unsigned fail_count,
	output int unsigned beats_due,
	output int unsigned sets_seen,
	output int unsigned values_seen
);
	import mse_pkg::*;

	typedef logic signed [FIELD_WIDTH-1:0] elem_t;
	typedef struct packed {
		elem_t value;
		logic  last_out;
	} sorted_beat_t;

	// Set being loaded, kept in stable ascending order as beats arrive.
	elem_t        open_set[$];
	// Sorted beats the block still owes, oldest first.
	sorted_beat_t sorted_due[$];

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t       due;
		elem_t              stored;
		logic signed [63:0] wide;
		int                 pos;
		if (!arst_n) begin
			open_set.delete();
			sorted_due.delete();
			beats_due = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (sorted_due.size() == 0) begin
					$display("%0t: sorted beat expected none, got %0d last_out %0b",
						$time, result.sorted_value, result.last_out);
					fail_count++;
				end else begin
					due = sorted_due.pop_front();
					if (result.sorted_value !== due.value) begin
						$display("%0t: sorted_value expected %0d, got %0d",
							$time, due.value, result.sorted_value);
						fail_count++;
					end
					if (result.last_out !== due.last_out) begin
						$display("%0t: last_out expected %0b, got %0b",
							$time, due.last_out, result.last_out);
						fail_count++;
					end
					values_seen++;
					if (due.last_out)
						sets_seen++;
				end
			end

			if (load.valid && load.ready) begin
				// Keep DATA_WIDTH bits, sign-extended back to the field width.
				wide = load.value;
				wide = (wide <<< (64 - DATA_WIDTH)) >>> (64 - DATA_WIDTH);
				stored = wide[FIELD_WIDTH-1:0];
				// Insert after any equal value so the order stays stable.
				pos = open_set.size();
				for (int i = 0; i < open_set.size(); i++) begin
					if (open_set[i] > stored) begin
						pos = i;
						break;
					end
				end
				open_set.insert(pos, stored);
				// A full buffer closes the set even without last.
				if (load.last || open_set.size() == MAX_ITEMS) begin
					foreach (open_set[i])
						sorted_due.push_back('{value: open_set[i],
							last_out: (i == open_set.size() - 1)});
					open_set.delete();
				end
			end
			beats_due = sorted_due.size();
		end
	end

endmodule

### tb/merge_sort_engine_unit_test.sv
// Testbench top for merge_sort_engine_unit: clock, reset, load stimulus and
// result back-pressure; checking is left to mse_sort_checker.
// Depends on mse_pkg, mse_if, the block and mse_sort_checker.
`timescale 1ns / 1ps

module merge_sort_engine_unit_test;
	import mse_pkg::*;

	localparam int          MAX_ITEMS    = 64;
	localparam int          DATA_WIDTH   = 32;
	localparam int unsigned ITEM_TARGET  = 260;
	localparam int unsigned QUIET_ITEMS  = 40;
	localparam int unsigned LONG_HOLD    = 1200;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	typedef logic signed [FIELD_WIDTH-1:0] elem_t;

	logic clk;
	logic arst_n;

	int unsigned fail_count;
	int unsigned beats_due;
	int unsigned sets_seen;
	int unsigned values_seen;
	int unsigned beats_sent;

	bit quiet_tail;
	bit hold_req;
	bit hold_done;

	mse_in_if  load_ch ();
	mse_out_if result_ch ();

	merge_sort_engine_unit #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load_ch),
		.result(result_ch)
	);

	mse_sort_checker #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.beats_due  (beats_due),
		.sets_seen  (sets_seen),
		.values_seen(values_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mix of extremes, a narrow band that forces ties, and full-range values.
	function automatic elem_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4: return elem_t'($urandom_range(0, 8)) - 4;
			default: return elem_t'($urandom);
		endcase
	endfunction

	// Offer one beat and return at the edge that accepts it.
	task automatic send_beat(input elem_t value, input logic last);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			load_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		load_ch.valid <= 1'b1;
		load_ch.value <= value;
		load_ch.last  <= last;
		@(posedge clk);
		while (!load_ch.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_set(input int unsigned len, input logic close_with_last);
		for (int unsigned i = 0; i < len; i++)
			send_beat(pick_value(), close_with_last && (i == len - 1));
	endtask

	// Result side: random stalls, free runs, and one long hold-off on request.
	initial begin
		int unsigned hold_count;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				hold_count = 0;
				while (hold_count < LONG_HOLD) begin
					@(posedge clk);
					hold_count++;
				end
				hold_done = 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timed out with %0d sorted beats still due", $time, beats_due);
		$display("merge_sort_engine_unit_test: errors");
		$finish;
	end

	initial begin
		int unsigned set_len;
		arst_n        <= 1'b0;
		load_ch.valid <= 1'b0;
		load_ch.value <= '0;
		load_ch.last  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-element sets at both extremes.
		send_beat(32'sh7fffffff, 1'b1);
		send_beat(32'sh80000000, 1'b1);
		// Two elements, reversed.
		send_beat(32'sh7fffffff, 1'b0);
		send_beat(32'sh80000000, 1'b1);
		// Ties among the elements.
		send_beat(32'sd3, 1'b0);
		send_beat(32'sd3, 1'b0);
		send_beat(-32'sd1, 1'b0);
		send_beat(32'sd3, 1'b1);
		// Sign boundary and repeated extremes.
		send_beat(32'sd0, 1'b0);
		send_beat(-32'sd1, 1'b0);
		send_beat(32'sd1, 1'b0);
		send_beat(32'sh80000000, 1'b0);
		send_beat(32'sh7fffffff, 1'b0);
		send_beat(32'sh80000000, 1'b0);
		send_beat(32'sh7fffffff, 1'b1);
		// Alternating bit patterns.
		send_beat(32'shffffffff, 1'b0);
		send_beat(32'sh55555555, 1'b0);
		send_beat(32'shaaaaaaaa, 1'b1);
		load_ch.valid <= 1'b0;
		@(posedge clk);
		wait (beats_due == 0);

		// Hold the result side while a full buffer and the next set are offered.
		hold_req = 1'b1;
		send_set(MAX_ITEMS, 1'b0);
		send_set(MAX_ITEMS, 1'b1);

		while (beats_sent < ITEM_TARGET) begin
			if (beats_sent + QUIET_ITEMS >= ITEM_TARGET)
				quiet_tail = 1'b1;
			if ($urandom_range(0, 7) == 0)
				set_len = $urandom_range(13, 40);
			else
				set_len = $urandom_range(1, 12);
			send_set(set_len, 1'b1);
		end
		load_ch.valid <= 1'b0;
		@(posedge clk);
		wait (beats_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d load beats in %0d sorted sets, %0d result beats checked",
			beats_sent, sets_seen, values_seen);
		$display("sets ran from one element to a full buffer, with a long result stall");
		if (fail_count == 0)
			$display("merge_sort_engine_unit_test: clean");
		else
			$display("merge_sort_engine_unit_test: errors");
		$finish;
	end

endmodule

### sim.f
sv/mse_pkg.sv
sv/mse_if.sv
sv/mse_ram.sv
sv/mse_seq.sv
sv/merge_sort_engine_unit.sv
tb/mse_sort_checker.sv
tb/merge_sort_engine_unit_test.sv
